@@ rtl/fpba_pkg.sv @@
// Shared codes, widths and controller/datapath handshake types for the block allocator.
`default_nettype none

package fpba_pkg;

  localparam int unsigned SIZE_W = 11;  // width of amount and chosen_size
  localparam int unsigned IDX_W  = 4;   // width of entry_index and chosen_index
  localparam int unsigned STAT_W = 2;
  localparam int unsigned POL_W  = 2;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_t;

  typedef enum logic [POL_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_t;

  typedef enum logic [STAT_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NOFIT     = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic item_take;  // input transfer this cycle: capture item, restart scan
    logic scan_en;    // issue one table read and advance the scan pointer
    logic commit;     // update table state and load the output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan pointer sits on the last entry
    logic out_free;   // output register can take a result this cycle
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/fpba_ifs.sv @@
// Valid/ready channel interfaces for the allocator's request and result streams.
`default_nettype none

interface fpba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [fpba_pkg::POL_W-1:0]    policy;
  logic [fpba_pkg::IDX_W-1:0]    entry_index;
  logic [fpba_pkg::SIZE_W-1:0]   amount;

  modport source (output valid, output cmd, output policy, output entry_index,
                  output amount, input ready);
  modport sink   (input valid, input cmd, input policy, input entry_index,
                  input amount, output ready);
endinterface

interface fpba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fpba_pkg::STAT_W-1:0]   status;
  logic [fpba_pkg::IDX_W-1:0]    chosen_index;
  logic [fpba_pkg::SIZE_W-1:0]   chosen_size;

  modport source (output valid, output status, output chosen_index,
                  output chosen_size, input ready);
  modport sink   (input valid, input status, input chosen_index,
                  input chosen_size, output ready);
endinterface

`default_nettype wire

@@ rtl/fpba_ctrl.sv @@
// Sequencing FSM: accept, table scan, drain of the read pipeline, writeback; loads go straight to writeback.
`default_nettype none

module fpba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  output logic                    in_ready,
  input  wire fpba_pkg::dp_sts_t  sts,
  output fpba_pkg::ctl_cmd_t      ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_WB
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == fpba_pkg::CMD_ALLOC) ? S_SCAN : S_WB;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_WB;
      S_WB: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign ctl.item_take = in_ready && in_valid;
  assign ctl.scan_en   = (state_r == S_SCAN);
  assign ctl.commit    = (state_r == S_WB) && sts.out_free;

endmodule

`default_nettype wire

@@ rtl/fpba_dp.sv @@
// Datapath: size memory, loaded/taken flags, scan compare and result register.
`default_nettype none

module fpba_dp #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned MAX_UNITS  = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fpba_pkg::ctl_cmd_t          ctl,
  output fpba_pkg::dp_sts_t                sts,
  input  wire logic                        in_cmd,
  input  wire logic [fpba_pkg::POL_W-1:0]  in_policy,
  input  wire logic [fpba_pkg::IDX_W-1:0]  in_entry_index,
  input  wire logic [fpba_pkg::SIZE_W-1:0] in_amount,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fpba_pkg::STAT_W-1:0]      out_status,
  output logic [fpba_pkg::IDX_W-1:0]       out_chosen_index,
  output logic [fpba_pkg::SIZE_W-1:0]      out_chosen_size
);

  localparam int unsigned AW     = $clog2(NUM_BLOCKS);
  localparam int unsigned SW     = fpba_pkg::SIZE_W;
  localparam logic [AW-1:0] LAST = AW'(NUM_BLOCKS - 1);

  // captured item
  logic                        cmd_r;
  logic [fpba_pkg::POL_W-1:0]  policy_r;
  logic [fpba_pkg::IDX_W-1:0]  idx_r;
  logic [SW-1:0]               amt_r;

  logic [SW-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] loaded_r;
  logic [NUM_BLOCKS-1:0] taken_r;

  // scan pipeline: address, then registered read data
  logic [AW-1:0] scan_addr_r;
  logic [AW-1:0] eval_idx_r;
  logic          eval_vld_r;
  logic [SW-1:0] rd_data_r;

  logic          found_r;
  logic [AW-1:0] pick_r;
  logic [SW-1:0] pick_size_r;

  logic                    out_valid_r;
  logic [fpba_pkg::STAT_W-1:0] status_r;
  logic [fpba_pkg::IDX_W-1:0]  chosen_idx_r;
  logic [SW-1:0]           chosen_size_r;

  logic          elig;
  logic          better;
  logic          in_range;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] amt_sat;

  assign in_range = 32'(idx_r) < NUM_BLOCKS;
  assign wr_addr  = AW'(idx_r);
  assign amt_sat  = (32'(amt_r) > MAX_UNITS) ? SW'(MAX_UNITS) : amt_r;

  assign elig = eval_vld_r && loaded_r[eval_idx_r] && !taken_r[eval_idx_r] &&
                (rd_data_r >= amt_r);

  always_comb begin
    better = 1'b0;
    if (elig) begin
      priority if (!found_r) begin
        better = 1'b1;
      end else if (policy_r == fpba_pkg::POL_BEST) begin
        better = rd_data_r < pick_size_r;
      end else if (policy_r == fpba_pkg::POL_WORST) begin
        better = rd_data_r > pick_size_r;
      end else begin
        better = 1'b0;  // first fit keeps the earliest hit
      end
    end
  end

  // item capture and scan state
  always_ff @(posedge clk) begin
    if (ctl.item_take) begin
      cmd_r    <= in_cmd;
      policy_r <= in_policy;
      idx_r    <= in_entry_index;
      amt_r    <= in_amount;
    end
    if (ctl.scan_en) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end else if (ctl.item_take) begin
      scan_addr_r <= '0;
    end
    eval_idx_r <= scan_addr_r;
    if (better) begin
      pick_r      <= eval_idx_r;
      pick_size_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_vld_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      eval_vld_r <= ctl.scan_en;
      if (ctl.item_take) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
    end
  end

  // size memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.commit && (cmd_r == fpba_pkg::CMD_LOAD) && in_range) begin
      mem[wr_addr] <= amt_sat;
    end
    rd_data_r <= mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      taken_r  <= '0;
    end else if (ctl.commit) begin
      if (cmd_r == fpba_pkg::CMD_LOAD) begin
        if (in_range) begin
          loaded_r[wr_addr] <= 1'b1;
          taken_r[wr_addr]  <= 1'b0;
        end
      end else if (found_r) begin
        taken_r[pick_r] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (cmd_r == fpba_pkg::CMD_LOAD) begin
        status_r      <= fpba_pkg::ST_LOADED;
        chosen_idx_r  <= idx_r;
        chosen_size_r <= amt_sat;
      end else if (found_r) begin
        status_r      <= fpba_pkg::ST_ALLOCATED;
        chosen_idx_r  <= fpba_pkg::IDX_W'(pick_r);
        chosen_size_r <= pick_size_r;
      end else begin
        status_r      <= fpba_pkg::ST_NOFIT;
        chosen_idx_r  <= '0;
        chosen_size_r <= '0;
      end
    end
  end

  assign sts.scan_last = (scan_addr_r == LAST);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_chosen_index = chosen_idx_r;
  assign out_chosen_size  = chosen_size_r;

endmodule

`default_nettype wire

@@ rtl/fit_policy_block_allocator.sv @@
// Top level of the first/best/worst fit block allocator.
//
// Keeps a table of NUM_BLOCKS blocks, each with a size (clamped to MAX_UNITS), a loaded flag
// and a taken flag. A load transfer writes one entry and frees it; it goes straight from
// acceptance to writeback. An allocate transfer walks the whole table through the single read
// port of the size memory, one entry per cycle, passing through acceptance, the scan of
// every entry, a drain of the registered read and the writeback.
// The picked entry is the lowest-index fit for first fit (policy three
// behaves the same), the smallest for best fit and the largest for worst fit, ties to the
// lowest index; entries never loaded are skipped. One item is worked on at a time; a
// finished result sits in the output register, so the next item is taken while it waits, and
// only the writeback stalls when the register is still full. No clearing pass follows reset:
// the flags clear at once and the size memory needs none.
`default_nettype none

module fit_policy_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned MAX_UNITS  = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fpba_req_if.sink    in_ch,
  fpba_rsp_if.source  out_ch
);

  fpba_pkg::ctl_cmd_t ctl;
  fpba_pkg::dp_sts_t  sts;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  fpba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_UNITS  (MAX_UNITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_ch.cmd),
    .in_policy        (in_ch.policy),
    .in_entry_index   (in_ch.entry_index),
    .in_amount        (in_ch.amount),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_chosen_index (out_ch.chosen_index),
    .out_chosen_size  (out_ch.chosen_size)
  );

  // Writeback only lands in a free output register.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |-> sts.out_free)
    else $error("result written over a pending transfer");

  // Every writeback shows up as a valid result on the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_ch.valid)
    else $error("writeback lost");

  // The scan stops after the last entry.
  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_en && sts.scan_last |=> !ctl.scan_en)
    else $error("scan ran past the table");

  // No new item enters while a scan is running.
  a_no_take_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_en |-> !ctl.item_take)
    else $error("item accepted during scan");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the first/best/worst fit block allocator.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned MAX_UNITS  = 1024;
  localparam int unsigned CYCLE_LIMIT = 300000;
  // policy code the package leaves unnamed; the block treats it as first fit
  localparam logic [fpba_pkg::POL_W-1:0] POL_SPARE = 2'd3;

  typedef struct {
    fpba_pkg::cmd_t                cmd;
    logic [fpba_pkg::POL_W-1:0]    policy;
    logic [fpba_pkg::IDX_W-1:0]    entry_index;
    logic [fpba_pkg::SIZE_W-1:0]   amount;
  } alloc_req_t;

  typedef struct {
    fpba_pkg::status_t             status;
    logic [fpba_pkg::IDX_W-1:0]    chosen_index;
    logic [fpba_pkg::SIZE_W-1:0]   chosen_size;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  fpba_req_if in_ch();
  fpba_rsp_if out_ch();

  fit_policy_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .MAX_UNITS (MAX_UNITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Shadow of the block table, advanced at each accepted request transfer.
  logic [fpba_pkg::SIZE_W-1:0] block_size   [NUM_BLOCKS];
  logic                        block_loaded [NUM_BLOCKS];
  logic                        block_taken  [NUM_BLOCKS];

  alloc_rsp_t pending_rsp_q[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         tx_idle_pct;
  int         rx_stall_pct;

  // Works out the response to one request and updates the shadow table, in the
  // order the block itself sees requests (order of acceptance).
  function automatic alloc_rsp_t predict_response(alloc_req_t r);
    alloc_rsp_t                  rsp;
    logic [fpba_pkg::SIZE_W-1:0] clamped;
    bit                          found;
    int                          pick;
    rsp.status       = fpba_pkg::ST_LOADED;
    rsp.chosen_index = r.entry_index;
    rsp.chosen_size  = '0;
    if (r.cmd == fpba_pkg::CMD_LOAD) begin
      // oversize loads are clamped to the largest block
      clamped = (r.amount > MAX_UNITS) ? fpba_pkg::SIZE_W'(MAX_UNITS) : r.amount;
      // the 4-bit index always lands inside a 16-entry table, so no load is dropped
      block_size[r.entry_index]   = clamped;
      block_loaded[r.entry_index] = 1'b1;
      block_taken[r.entry_index]  = 1'b0;  // a reload frees the entry again
      rsp.chosen_size = clamped;
      return rsp;
    end
    found = 1'b0;
    pick  = 0;
    // never-loaded entries are skipped, so their undefined sizes are never looked at
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (block_loaded[i] && !block_taken[i] && block_size[i] >= r.amount) begin
        if (!found) begin
          found = 1'b1;
          pick  = i;
        end else if (r.policy == fpba_pkg::POL_BEST && block_size[i] < block_size[pick]) begin
          pick = i;
        end else if (r.policy == fpba_pkg::POL_WORST && block_size[i] > block_size[pick]) begin
          pick = i;
        end
        // strict compares keep ties on the lowest index; first fit and the
        // spare policy code never move off the first hit
      end
    end
    if (!found) begin
      rsp.status       = fpba_pkg::ST_NOFIT;
      rsp.chosen_index = '0;
      return rsp;
    end
    block_taken[pick] = 1'b1;
    rsp.status        = fpba_pkg::ST_ALLOCATED;
    rsp.chosen_index  = fpba_pkg::IDX_W'(pick);
    rsp.chosen_size   = block_size[pick];
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH @%0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Presents one request, holding valid until the transfer happens. Random idle
  // cycles go in front; valid is left high afterwards so back-to-back transfers
  // never drop it, and the next call (or the end of the run) decides its level.
  task automatic send_request(alloc_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= r.cmd;
    in_ch.policy      <= r.policy;
    in_ch.entry_index <= r.entry_index;
    in_ch.amount      <= r.amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_rsp_q.push_back(predict_response(r));
  endtask

  task automatic send_load(int idx, int amount);
    alloc_req_t r;
    r.cmd         = fpba_pkg::CMD_LOAD;
    r.policy      = fpba_pkg::POL_W'($urandom_range(3));  // don't-care on a load
    r.entry_index = fpba_pkg::IDX_W'(idx);
    r.amount      = fpba_pkg::SIZE_W'(amount);
    send_request(r);
  endtask

  task automatic send_alloc(logic [fpba_pkg::POL_W-1:0] policy, int amount);
    alloc_req_t r;
    r.cmd         = fpba_pkg::CMD_ALLOC;
    r.policy      = policy;
    r.entry_index = fpba_pkg::IDX_W'($urandom_range(15));  // don't-care on a request
    r.amount      = fpba_pkg::SIZE_W'(amount);
    send_request(r);
  endtask

  // Result side: ready toggles at random, and each result transfer is checked
  // against the oldest outstanding prediction.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_ch.status), -1);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", int'(out_ch.status), int'(want.status));
        if (out_ch.chosen_index !== want.chosen_index)
          report_mismatch("chosen_index", int'(out_ch.chosen_index), int'(want.chosen_index));
        if (out_ch.chosen_size !== want.chosen_size)
          report_mismatch("chosen_size", int'(out_ch.chosen_size), int'(want.chosen_size));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fit_policy_block_allocator verification failed");
      $finish;
    end
  end

  // Allocation on an empty table must miss, even for a zero-size request.
  task automatic test_empty_table();
    send_alloc(fpba_pkg::POL_FIRST, 0);
    send_alloc(fpba_pkg::POL_WORST, 2047);
  endtask

  // Extremes of index and size, including loads above the largest block.
  task automatic test_load_extremes();
    send_load(0, 2047);   // clamps
    send_load(15, 0);
    send_load(5, 300);
    send_load(9, 300);    // ties with entry 5
    send_load(10, 1025);  // clamps, ties with entry 0
    send_load(3, 100);
  endtask

  // Every policy, tie-breaks, exact fits, misses and a reload of a taken entry.
  task automatic test_fit_policies();
    send_alloc(fpba_pkg::POL_BEST, 250);    // tie between 5 and 9
    send_alloc(fpba_pkg::POL_WORST, 500);   // tie between 0 and 10
    send_alloc(POL_SPARE, 200);             // behaves as first fit
    send_alloc(fpba_pkg::POL_FIRST, 0);
    send_alloc(fpba_pkg::POL_BEST, 0);      // zero-size block fits a zero request
    send_alloc(fpba_pkg::POL_WORST, 1025);  // above every size
    send_alloc(fpba_pkg::POL_FIRST, 1024);
    send_alloc(fpba_pkg::POL_BEST, 1);      // table exhausted
    send_load(5, 1024);                     // reload frees the entry
    send_alloc(fpba_pkg::POL_WORST, 1024);
    send_alloc(POL_SPARE, 2047);
  endtask

  // Mostly loads and requests that can land; some oversize values as noise.
  task automatic random_burst(int n);
    alloc_req_t r;
    int         sel;
    repeat (n) begin
      sel           = $urandom_range(99);
      r.policy      = fpba_pkg::POL_W'($urandom_range(3));
      r.entry_index = fpba_pkg::IDX_W'($urandom_range(15));
      if (sel < 42) begin
        r.cmd = fpba_pkg::CMD_LOAD;
        if (sel < 4)
          r.amount = fpba_pkg::SIZE_W'($urandom_range(2047, 1025));
        else if (sel < 24)
          r.amount = fpba_pkg::SIZE_W'($urandom_range(64));
        else
          r.amount = fpba_pkg::SIZE_W'($urandom_range(MAX_UNITS));
      end else begin
        r.cmd = fpba_pkg::CMD_ALLOC;
        if (sel < 50 && block_loaded[r.entry_index])
          r.amount = block_size[r.entry_index];  // exact fit against a live entry
        else if (sel < 85)
          r.amount = fpba_pkg::SIZE_W'($urandom_range(256));
        else if (sel < 96)
          r.amount = fpba_pkg::SIZE_W'($urandom_range(MAX_UNITS));
        else
          r.amount = fpba_pkg::SIZE_W'($urandom_range(2047, 1025));
      end
      send_request(r);
    end
  endtask

  task automatic test_random_output_backpressure();
    tx_idle_pct  = 18;
    rx_stall_pct = 83;
    random_burst(250);
  endtask

  task automatic test_random_input_gaps();
    tx_idle_pct  = 83;
    rx_stall_pct = 18;
    random_burst(250);
  endtask

  task automatic test_random_full_rate();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_burst(250);
  endtask

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      block_size[i]   = '0;
      block_loaded[i] = 1'b0;
      block_taken[i]  = 1'b0;
    end
    tx_idle_pct       = 18;
    rx_stall_pct      = 83;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = fpba_pkg::CMD_LOAD;
    in_ch.policy      = fpba_pkg::POL_FIRST;
    in_ch.entry_index = '0;
    in_ch.amount      = '0;
    out_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_load_extremes();
    test_fit_policies();
    test_random_output_backpressure();
    test_random_input_gaps();
    test_random_full_rate();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    // catch any stray result that turns up after the last expected one
    repeat (40) @(posedge clk);
    if (pending_rsp_q.size() != 0)
      report_mismatch("results still outstanding", 0, pending_rsp_q.size());

    if (mismatches == 0) begin
      $display("fit_policy_block_allocator verification clean");
    end else begin
      $display("fit_policy_block_allocator verification failed");
    end
    $finish;
  end

endmodule

@@ fit_policy_block_allocator.f @@
rtl/fpba_pkg.sv
rtl/fpba_ifs.sv
rtl/fpba_ctrl.sv
rtl/fpba_dp.sv
rtl/fit_policy_block_allocator.sv
sim/tb.sv
